/* src/ubd_pkg.sv */
package ubd_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_TIME_W  = 16;
    localparam int COUNT_W     = 8;
    localparam int PHASE_W     = 2;

    localparam logic [PHASE_W-1:0] PH_BURST  = 2'd0;
    localparam logic [PHASE_W-1:0] PH_LISTEN = 2'd1;
    localparam logic [PHASE_W-1:0] PH_GAP    = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_BURST_PULSES     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_PERIOD     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_HIGH_START = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LISTEN_TICKS     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_GAP_TICKS        = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_ECHO_THRESHOLD   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_RUN_ENABLE       = 3'd6;

    localparam logic [COUNT_W-1:0]    RST_BURST_PULSES     = 8'd30;
    localparam logic [CFG_TIME_W-1:0] RST_PULSE_PERIOD     = 16'd30;
    localparam logic [CFG_TIME_W-1:0] RST_PULSE_HIGH_START = 16'd15;
    localparam logic [CFG_TIME_W-1:0] RST_LISTEN_TICKS     = 16'd1200;
    localparam logic [CFG_TIME_W-1:0] RST_GAP_TICKS        = 16'd60000;
    localparam logic [COUNT_W-1:0]    RST_ECHO_THRESHOLD   = 8'd30;
    localparam logic                  RST_RUN_ENABLE       = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    typedef struct packed {
        logic [COUNT_W-1:0]    burst_pulses;
        logic [CFG_TIME_W-1:0] pulse_period;
        logic [CFG_TIME_W-1:0] pulse_high_start;
        logic [CFG_TIME_W-1:0] listen_ticks;
        logic [CFG_TIME_W-1:0] gap_ticks;
        logic [COUNT_W-1:0]    echo_threshold;
        logic                  run_enable;
    } cfg_t;

    typedef struct packed {
        logic               tx_level;
        logic [PHASE_W-1:0] phase_now;
        logic               decision_valid;
        logic               bubble_present;
        logic               no_bubble;
        logic [COUNT_W-1:0] edges_seen;
    } res_t;

endpackage

/* src/ubd_cfg.sv */
module ubd_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [ubd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ubd_pkg::CFG_DATA_W-1:0]    cfg_data,
    output ubd_pkg::cfg_t                     cfg
);

    ubd_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.burst_pulses     <= ubd_pkg::RST_BURST_PULSES;
            cfg_reg.pulse_period     <= ubd_pkg::RST_PULSE_PERIOD;
            cfg_reg.pulse_high_start <= ubd_pkg::RST_PULSE_HIGH_START;
            cfg_reg.listen_ticks     <= ubd_pkg::RST_LISTEN_TICKS;
            cfg_reg.gap_ticks        <= ubd_pkg::RST_GAP_TICKS;
            cfg_reg.echo_threshold   <= ubd_pkg::RST_ECHO_THRESHOLD;
            cfg_reg.run_enable       <= ubd_pkg::RST_RUN_ENABLE;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                ubd_pkg::REG_BURST_PULSES:
                    cfg_reg.burst_pulses <= cfg_data[ubd_pkg::COUNT_W-1:0];
                ubd_pkg::REG_PULSE_PERIOD:
                    cfg_reg.pulse_period <= cfg_data[ubd_pkg::CFG_TIME_W-1:0];
                ubd_pkg::REG_PULSE_HIGH_START:
                    cfg_reg.pulse_high_start <= cfg_data[ubd_pkg::CFG_TIME_W-1:0];
                ubd_pkg::REG_LISTEN_TICKS:
                    cfg_reg.listen_ticks <= cfg_data[ubd_pkg::CFG_TIME_W-1:0];
                ubd_pkg::REG_GAP_TICKS:
                    cfg_reg.gap_ticks <= cfg_data[ubd_pkg::CFG_TIME_W-1:0];
                ubd_pkg::REG_ECHO_THRESHOLD:
                    cfg_reg.echo_threshold <= cfg_data[ubd_pkg::COUNT_W-1:0];
                ubd_pkg::REG_RUN_ENABLE:
                    cfg_reg.run_enable <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* src/ubd_seq.sv */
module ubd_seq
#(
    parameter int TIMER_WIDTH = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic          rx,
    input  ubd_pkg::cfg_t cfg,
    output ubd_pkg::res_t res
);

    localparam int CMPW = ((TIMER_WIDTH > ubd_pkg::CFG_TIME_W) ?
                           TIMER_WIDTH : ubd_pkg::CFG_TIME_W) + 1;

    logic [ubd_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0]      tick_count_reg, tick_count_next;
    logic [ubd_pkg::COUNT_W-1:0] pulse_count_reg, pulse_count_next;
    logic [ubd_pkg::COUNT_W-1:0] echo_count_reg, echo_count_next;
    logic                        rx_prev_reg;
    logic                        bubble_flag_reg, bubble_flag_next;
    logic                        clear_flag_reg, clear_flag_next;

    logic [CMPW-1:0]             tick_inc;
    logic                        tick_full;
    logic                        done_pulse;
    logic                        done_listen;
    logic                        done_gap;
    logic                        rising;
    logic [ubd_pkg::COUNT_W-1:0] pulse_inc;
    logic [ubd_pkg::COUNT_W-1:0] echo_inc;
    logic                        tx;
    logic                        decided;
    logic [ubd_pkg::PHASE_W-1:0] shown;

    // A period ends once the count plus one reaches its length, or the timer is full.
    assign tick_inc    = CMPW'(tick_count_reg) + CMPW'(1);
    assign tick_full   = (tick_count_reg == {TIMER_WIDTH{1'b1}});
    assign done_pulse  = (tick_inc >= CMPW'(cfg.pulse_period)) || tick_full;
    assign done_listen = (tick_inc >= CMPW'(cfg.listen_ticks)) || tick_full;
    assign done_gap    = (tick_inc >= CMPW'(cfg.gap_ticks)) || tick_full;

    assign rising    = rx && !rx_prev_reg;
    assign pulse_inc = pulse_count_reg + ubd_pkg::COUNT_W'(1);
    assign echo_inc  = (rising && (echo_count_reg != ubd_pkg::COUNT_MAX)) ?
                       echo_count_reg + ubd_pkg::COUNT_W'(1) : echo_count_reg;

    always_comb
    begin
        phase_next       = phase_reg;
        tick_count_next  = tick_count_reg;
        pulse_count_next = pulse_count_reg;
        echo_count_next  = echo_count_reg;
        bubble_flag_next = bubble_flag_reg;
        clear_flag_next  = clear_flag_reg;
        tx               = 1'b0;
        decided          = 1'b0;
        shown            = ubd_pkg::PH_GAP;
        unique case (phase_reg)
            ubd_pkg::PH_BURST:
            begin
                shown = ubd_pkg::PH_BURST;
                tx    = (CMPW'(tick_count_reg) >= CMPW'(cfg.pulse_high_start));
                if (done_pulse)
                begin
                    tick_count_next = '0;
                    if (pulse_inc >= cfg.burst_pulses)
                    begin
                        pulse_count_next = '0;
                        echo_count_next  = '0;
                        phase_next       = ubd_pkg::PH_LISTEN;
                    end
                    else
                    begin
                        pulse_count_next = pulse_inc;
                    end
                end
                else
                begin
                    tick_count_next = tick_inc[TIMER_WIDTH-1:0];
                end
            end
            ubd_pkg::PH_LISTEN:
            begin
                shown           = ubd_pkg::PH_LISTEN;
                echo_count_next = echo_inc;
                if (done_listen)
                begin
                    decided          = 1'b1;
                    clear_flag_next  = (echo_inc >= cfg.echo_threshold);
                    bubble_flag_next = !(echo_inc >= cfg.echo_threshold);
                    tick_count_next  = '0;
                    phase_next       = ubd_pkg::PH_GAP;
                end
                else
                begin
                    tick_count_next = tick_inc[TIMER_WIDTH-1:0];
                end
            end
            default:
            begin
                // The gap code and any undefined code behave as gap.
                phase_next = ubd_pkg::PH_GAP;
                if (done_gap)
                begin
                    if (cfg.run_enable)
                    begin
                        tick_count_next  = '0;
                        pulse_count_next = '0;
                        phase_next       = ubd_pkg::PH_BURST;
                    end
                end
                else
                begin
                    tick_count_next = tick_inc[TIMER_WIDTH-1:0];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= ubd_pkg::PH_BURST;
            tick_count_reg  <= '0;
            pulse_count_reg <= '0;
            echo_count_reg  <= '0;
            rx_prev_reg     <= 1'b0;
            bubble_flag_reg <= 1'b0;
            clear_flag_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            tick_count_reg  <= tick_count_next;
            pulse_count_reg <= pulse_count_next;
            echo_count_reg  <= echo_count_next;
            rx_prev_reg     <= rx;
            bubble_flag_reg <= bubble_flag_next;
            clear_flag_reg  <= clear_flag_next;
        end
    end

    assign res.tx_level       = tx;
    assign res.phase_now      = shown;
    assign res.decision_valid = decided;
    assign res.bubble_present = bubble_flag_next;
    assign res.no_bubble      = clear_flag_next;
    assign res.edges_seen     = echo_count_next;

endmodule

/* src/ultrasonic_bubble_detector_sequencer_unit.sv */
// Channel   Direction  Handshake           Word
// input     in         in_valid/in_stall   rx_level
// output    out        out_valid/out_stall tx_level, phase_now, decision_valid,
//                                          bubble_present, no_bubble, edges_seen
// config    in         cfg_write           cfg_index, cfg_data
//
// A word that is accepted sits in the input register, and its result is loaded into the
// result register when the sequencer steps, which a stall on the output can hold back.
// A new word is accepted every cycle while the output is not stalled; the rate is set by the single sequencer step.
// Reset is asynchronous, active low, and returns all but rx_reg and res_reg to defaults.
// A stall on the output holds the result register, and the input side stalls only
// when both the input and result registers are full.
module ultrasonic_bubble_detector_sequencer_unit
#(
    parameter int TIMER_WIDTH = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              rx_level,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              tx_level,
    output logic [ubd_pkg::PHASE_W-1:0]       phase_now,
    output logic                              decision_valid,
    output logic                              bubble_present,
    output logic                              no_bubble,
    output logic [ubd_pkg::COUNT_W-1:0]       edges_seen,
    input  logic                              cfg_write,
    input  logic [ubd_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ubd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    ubd_pkg::cfg_t cfg;
    ubd_pkg::res_t res;
    ubd_pkg::res_t res_reg;

    logic in_valid_reg;
    logic rx_reg;
    logic out_valid_reg;
    logic in_accept;
    logic advance;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    ubd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ubd_seq
    #(
        .TIMER_WIDTH (TIMER_WIDTH)
    )
    u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .rx    (rx_reg),
        .cfg   (cfg),
        .res   (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            rx_reg <= rx_level;
        end
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid      = out_valid_reg;
    assign tx_level       = res_reg.tx_level;
    assign phase_now      = res_reg.phase_now;
    assign decision_valid = res_reg.decision_valid;
    assign bubble_present = res_reg.bubble_present;
    assign no_bubble      = res_reg.no_bubble;
    assign edges_seen     = res_reg.edges_seen;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && decision_valid) |-> (phase_now == ubd_pkg::PH_LISTEN))
        else $error("decision shown outside the listen phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(bubble_present && no_bubble))
        else $error("bubble and no-bubble flags set together");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tx_level) |-> (phase_now == ubd_pkg::PH_BURST))
        else $error("transmit driven outside the burst phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while the result register can move");
`endif

endmodule

/* sim/ultrasonic_bubble_detector_sequencer_unit_tb.sv */
`timescale 1ns / 100ps

module ultrasonic_bubble_detector_sequencer_unit_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int TIMER_W      = 16;
    localparam int RANDOM_TICKS = 850;
    localparam int HOLD_AFTER   = 300;
    localparam int HOLD_CYCLES  = 80;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic {ROW_TICK, ROW_REG} row_kind_t;

    typedef enum logic [2:0] {
        PROFILE_SHORT,
        PROFILE_EXTREME,
        PROFILE_HOLD,
        PROFILE_SATURATE,
        PROFILE_ZERO
    } cfg_profile_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [ubd_pkg::CFG_INDEX_W-1:0] idx;
        logic [ubd_pkg::CFG_DATA_W-1:0]  value;
        logic                            rx;
        logic                            typed;
        ubd_pkg::res_t                   want;
    } row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_stall;
    logic                            rx_level = 1'b0;
    logic                            out_valid;
    logic                            out_stall = 1'b0;
    logic                            tx_level;
    logic [ubd_pkg::PHASE_W-1:0]     phase_now;
    logic                            decision_valid;
    logic                            bubble_present;
    logic                            no_bubble;
    logic [ubd_pkg::COUNT_W-1:0]     edges_seen;
    logic                            cfg_write = 1'b0;
    logic [ubd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [ubd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    ubd_pkg::cfg_t               seq_cfg;
    logic [ubd_pkg::PHASE_W-1:0] seq_phase;
    logic [TIMER_W-1:0]          seq_ticks;
    logic [ubd_pkg::COUNT_W-1:0] seq_pulses;
    logic [ubd_pkg::COUNT_W-1:0] seq_edges;
    logic                        seq_rx_prev;
    logic                        seq_bubble;
    logic                        seq_clear;

    ubd_pkg::res_t outputs_due[$];
    row_t stimulus_rows[$];
    int   ticks_sent = 0;
    int   burst_left = 0;
    int   failures = 0;
    int   cycle_count = 0;
    logic long_hold_done = 1'b0;
    logic echo_line = 1'b0;

    ultrasonic_bubble_detector_sequencer_unit #(
        .TIMER_WIDTH(TIMER_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_level      (rx_level),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .tx_level      (tx_level),
        .phase_now     (phase_now),
        .decision_valid(decision_valid),
        .bubble_present(bubble_present),
        .no_bubble     (no_bubble),
        .edges_seen    (edges_seen),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void reset_sequencer();
        seq_cfg.burst_pulses     = ubd_pkg::RST_BURST_PULSES;
        seq_cfg.pulse_period     = ubd_pkg::RST_PULSE_PERIOD;
        seq_cfg.pulse_high_start = ubd_pkg::RST_PULSE_HIGH_START;
        seq_cfg.listen_ticks     = ubd_pkg::RST_LISTEN_TICKS;
        seq_cfg.gap_ticks        = ubd_pkg::RST_GAP_TICKS;
        seq_cfg.echo_threshold   = ubd_pkg::RST_ECHO_THRESHOLD;
        seq_cfg.run_enable       = ubd_pkg::RST_RUN_ENABLE;
        seq_phase   = ubd_pkg::PH_BURST;
        seq_ticks   = '0;
        seq_pulses  = '0;
        seq_edges   = '0;
        seq_rx_prev = 1'b0;
        seq_bubble  = 1'b0;
        seq_clear   = 1'b0;
    endfunction

    // A length of zero or one ends after a single tick; a full timer also ends the period.
    function automatic logic timer_expired(input logic [ubd_pkg::CFG_TIME_W-1:0] span);
        return (32'(seq_ticks) + 32'd1 >= 32'(span)) || (seq_ticks == '1);
    endfunction

    function automatic ubd_pkg::res_t step_sequencer(input logic rx);
        ubd_pkg::res_t view;
        logic rising;
        rising = rx && !seq_rx_prev;
        view = '0;
        view.phase_now = seq_phase;
        case (seq_phase)
            ubd_pkg::PH_BURST:
            begin
                view.tx_level = (32'(seq_ticks) >= 32'(seq_cfg.pulse_high_start));
                if (timer_expired(seq_cfg.pulse_period))
                begin
                    seq_ticks  = '0;
                    seq_pulses = seq_pulses + 8'd1;
                    if (seq_pulses >= seq_cfg.burst_pulses)
                    begin
                        seq_pulses = '0;
                        seq_edges  = '0;
                        seq_phase  = ubd_pkg::PH_LISTEN;
                    end
                end
                else
                begin
                    seq_ticks++;
                end
            end
            ubd_pkg::PH_LISTEN:
            begin
                if (rising && seq_edges != ubd_pkg::COUNT_MAX)
                begin
                    seq_edges++;
                end
                if (timer_expired(seq_cfg.listen_ticks))
                begin
                    view.decision_valid = 1'b1;
                    seq_clear  = (seq_edges >= seq_cfg.echo_threshold);
                    seq_bubble = !seq_clear;
                    seq_ticks  = '0;
                    seq_phase  = ubd_pkg::PH_GAP;
                end
                else
                begin
                    seq_ticks++;
                end
            end
            default:
            begin
                seq_phase = ubd_pkg::PH_GAP;
                if (timer_expired(seq_cfg.gap_ticks))
                begin
                    if (seq_cfg.run_enable)
                    begin
                        seq_ticks  = '0;
                        seq_pulses = '0;
                        seq_phase  = ubd_pkg::PH_BURST;
                    end
                end
                else
                begin
                    seq_ticks++;
                end
            end
        endcase
        seq_rx_prev = rx;
        view.bubble_present = seq_bubble;
        view.no_bubble      = seq_clear;
        view.edges_seen     = seq_edges;
        return view;
    endfunction

    function automatic row_t tick_row(input logic rx);
        row_t row;
        row = '0;
        row.kind = ROW_TICK;
        row.rx = rx;
        return row;
    endfunction

    function automatic row_t checked_row(input logic rx, input ubd_pkg::res_t want);
        row_t row;
        row = tick_row(rx);
        row.typed = 1'b1;
        row.want = want;
        return row;
    endfunction

    function automatic row_t reg_row(input logic [ubd_pkg::CFG_INDEX_W-1:0] idx,
                                     input logic [ubd_pkg::CFG_DATA_W-1:0] value);
        row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.idx = idx;
        row.value = value;
        return row;
    endfunction

    task automatic offer_tick(input logic rx, input logic typed, input ubd_pkg::res_t want);
        int            idle;
        ubd_pkg::res_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            idle = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 4);
            if (idle > 0)
            begin
                in_valid <= 1'b0;
                rx_level <= 1'($urandom_range(1));
                repeat (idle) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        rx_level <= rx;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = step_sequencer(rx);
        outputs_due.push_back(typed ? want : predicted);
        ticks_sent++;
    endtask

    task automatic settle_outputs();
        in_valid <= 1'b0;
        while (outputs_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [ubd_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [ubd_pkg::CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            ubd_pkg::REG_BURST_PULSES:
                seq_cfg.burst_pulses = value[ubd_pkg::COUNT_W-1:0];
            ubd_pkg::REG_PULSE_PERIOD:     seq_cfg.pulse_period = value;
            ubd_pkg::REG_PULSE_HIGH_START: seq_cfg.pulse_high_start = value;
            ubd_pkg::REG_LISTEN_TICKS:     seq_cfg.listen_ticks = value;
            ubd_pkg::REG_GAP_TICKS:        seq_cfg.gap_ticks = value;
            ubd_pkg::REG_ECHO_THRESHOLD:
                seq_cfg.echo_threshold = value[ubd_pkg::COUNT_W-1:0];
            ubd_pkg::REG_RUN_ENABLE:       seq_cfg.run_enable = value[0];
            default:                       ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_profile(input cfg_profile_t profile);
        logic [ubd_pkg::CFG_DATA_W-1:0] pulses;
        logic [ubd_pkg::CFG_DATA_W-1:0] period;
        logic [ubd_pkg::CFG_DATA_W-1:0] high_start;
        logic [ubd_pkg::CFG_DATA_W-1:0] listen;
        logic [ubd_pkg::CFG_DATA_W-1:0] gap;
        logic [ubd_pkg::CFG_DATA_W-1:0] threshold;
        logic                           run;
        int                             words;
        int                             toggle_pct;
        pulses     = 16'($urandom_range(1, 4));
        period     = 16'($urandom_range(2, 8));
        high_start = 16'($urandom_range(0, period + 1));
        listen     = 16'($urandom_range(4, 40));
        gap        = 16'($urandom_range(1, 12));
        threshold  = 16'($urandom_range(0, listen / 2 + 1));
        run        = 1'b1;
        words      = $urandom_range(30, 80);
        toggle_pct = $urandom_range(4) * 25;
        case (profile)
            PROFILE_EXTREME:
            begin
                pulses     = 16'd255;
                period     = 16'hFFFF;
                high_start = 16'hFFFF;
                listen     = 16'hFFFF;
                gap        = 16'hFFFF;
                threshold  = 16'd255;
                words      = 40;
            end
            PROFILE_HOLD:
            begin
                gap   = 16'($urandom_range(1, 4));
                run   = 1'b0;
                words = 30;
            end
            PROFILE_SATURATE:
            begin
                pulses     = 16'd1;
                period     = 16'd2;
                high_start = 16'd1;
                listen     = 16'd520;
                gap        = 16'd3;
                threshold  = 16'd255;
                words      = 545;
                toggle_pct = 100;
            end
            PROFILE_ZERO:
            begin
                pulses     = 16'($urandom_range(1));
                period     = 16'($urandom_range(1));
                high_start = 16'($urandom_range(1));
                listen     = 16'($urandom_range(1));
                gap        = 16'($urandom_range(1));
                threshold  = 16'($urandom_range(1));
                words      = 30;
            end
            default: ;
        endcase
        settle_outputs();
        write_reg(ubd_pkg::REG_BURST_PULSES, pulses);
        write_reg(ubd_pkg::REG_PULSE_PERIOD, period);
        write_reg(ubd_pkg::REG_PULSE_HIGH_START, high_start);
        write_reg(ubd_pkg::REG_LISTEN_TICKS, listen);
        write_reg(ubd_pkg::REG_GAP_TICKS, gap);
        write_reg(ubd_pkg::REG_ECHO_THRESHOLD, threshold);
        write_reg(ubd_pkg::REG_RUN_ENABLE, 16'(run));
        repeat (words)
        begin
            echo_line = echo_line ^ ($urandom_range(99) < toggle_pct);
            offer_tick(echo_line, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ultrasonic_bubble_detector_sequencer_unit regression: fail");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        ubd_pkg::res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (outputs_due.size() == 0)
            begin
                $error("unexpected word on the output");
                failures++;
            end
            else
            begin
                want = outputs_due.pop_front();
                if (tx_level !== want.tx_level)
                begin
                    $error("tx_level: expected %0d, got %0d", want.tx_level, tx_level);
                    failures++;
                end
                if (phase_now !== want.phase_now)
                begin
                    $error("phase_now: expected %0d, got %0d", want.phase_now, phase_now);
                    failures++;
                end
                if (decision_valid !== want.decision_valid)
                begin
                    $error("decision_valid: expected %0d, got %0d",
                           want.decision_valid, decision_valid);
                    failures++;
                end
                if (bubble_present !== want.bubble_present)
                begin
                    $error("bubble_present: expected %0d, got %0d",
                           want.bubble_present, bubble_present);
                    failures++;
                end
                if (no_bubble !== want.no_bubble)
                begin
                    $error("no_bubble: expected %0d, got %0d", want.no_bubble, no_bubble);
                    failures++;
                end
                if (edges_seen !== want.edges_seen)
                begin
                    $error("edges_seen: expected %0d, got %0d", want.edges_seen, edges_seen);
                    failures++;
                end
            end
        end
    end

    // The one long hold lets the block fill up and push back on its input.
    initial
    begin
        int run_len;
        int hold_len;
        wait (rst_n === 1'b1);
        forever
        begin
            run_len = ($urandom_range(7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            repeat (run_len) @(posedge clk);
            if (!long_hold_done && ticks_sent >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                hold_len = HOLD_CYCLES;
            end
            else
            begin
                hold_len = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 3);
            end
            if (hold_len > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_len) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int first_random;
        reset_sequencer();
        stimulus_rows.push_back(checked_row(1'b0,
            ubd_pkg::res_t'{1'b0, ubd_pkg::PH_BURST, 1'b0, 1'b0, 1'b0, 8'd0}));
        stimulus_rows.push_back(checked_row(1'b1,
            ubd_pkg::res_t'{1'b0, ubd_pkg::PH_BURST, 1'b0, 1'b0, 1'b0, 8'd0}));
        stimulus_rows.push_back(reg_row(ubd_pkg::REG_BURST_PULSES, 16'd1));
        stimulus_rows.push_back(reg_row(ubd_pkg::REG_PULSE_PERIOD, 16'd2));
        stimulus_rows.push_back(reg_row(ubd_pkg::REG_PULSE_HIGH_START, 16'd1));
        stimulus_rows.push_back(reg_row(ubd_pkg::REG_LISTEN_TICKS, 16'd4));
        stimulus_rows.push_back(reg_row(ubd_pkg::REG_GAP_TICKS, 16'd1));
        stimulus_rows.push_back(reg_row(ubd_pkg::REG_ECHO_THRESHOLD, 16'd2));
        stimulus_rows.push_back(reg_row(ubd_pkg::REG_RUN_ENABLE, 16'd1));
        stimulus_rows.push_back(tick_row(1'b0));
        stimulus_rows.push_back(tick_row(1'b1));
        stimulus_rows.push_back(tick_row(1'b0));
        stimulus_rows.push_back(tick_row(1'b1));
        stimulus_rows.push_back(tick_row(1'b0));
        stimulus_rows.push_back(tick_row(1'b0));
        stimulus_rows.push_back(tick_row(1'b0));
        stimulus_rows.push_back(tick_row(1'b0));
        stimulus_rows.push_back(tick_row(1'b0));
        stimulus_rows.push_back(tick_row(1'b0));
        stimulus_rows.push_back(tick_row(1'b0));
        stimulus_rows.push_back(tick_row(1'b0));
        stimulus_rows.push_back(tick_row(1'b1));
        stimulus_rows.push_back(reg_row(ubd_pkg::REG_BURST_PULSES, 16'd0));
        stimulus_rows.push_back(reg_row(ubd_pkg::REG_PULSE_PERIOD, 16'd0));
        stimulus_rows.push_back(reg_row(ubd_pkg::REG_PULSE_HIGH_START, 16'd0));
        stimulus_rows.push_back(reg_row(ubd_pkg::REG_LISTEN_TICKS, 16'd1));
        stimulus_rows.push_back(reg_row(ubd_pkg::REG_GAP_TICKS, 16'd0));
        stimulus_rows.push_back(reg_row(ubd_pkg::REG_ECHO_THRESHOLD, 16'd0));
        stimulus_rows.push_back(tick_row(1'b0));
        stimulus_rows.push_back(tick_row(1'b1));
        stimulus_rows.push_back(tick_row(1'b0));
        stimulus_rows.push_back(tick_row(1'b1));
        stimulus_rows.push_back(reg_row(ubd_pkg::REG_RUN_ENABLE, 16'd0));
        stimulus_rows.push_back(tick_row(1'b0));
        stimulus_rows.push_back(tick_row(1'b0));
        stimulus_rows.push_back(tick_row(1'b1));
        stimulus_rows.push_back(reg_row(ubd_pkg::REG_RUN_ENABLE, 16'd1));
        stimulus_rows.push_back(tick_row(1'b0));
        stimulus_rows.push_back(tick_row(1'b0));

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stimulus_rows[i])
        begin
            if (stimulus_rows[i].kind == ROW_REG)
            begin
                settle_outputs();
                write_reg(stimulus_rows[i].idx, stimulus_rows[i].value);
            end
            else
            begin
                offer_tick(stimulus_rows[i].rx, stimulus_rows[i].typed, stimulus_rows[i].want);
            end
        end

        first_random = ticks_sent;
        for (int n = 0; ticks_sent - first_random < RANDOM_TICKS; n++)
        begin
            case (n)
                1:       run_profile(PROFILE_EXTREME);
                3:       run_profile(PROFILE_HOLD);
                4:       run_profile(PROFILE_SATURATE);
                6:       run_profile(PROFILE_ZERO);
                8:       run_profile(PROFILE_HOLD);
                9:       run_profile(PROFILE_ZERO);
                default: run_profile(PROFILE_SHORT);
            endcase
        end

        settle_outputs();
        repeat (10) @(posedge clk);
        if (failures == 0 && outputs_due.size() == 0)
        begin
            $display("ultrasonic_bubble_detector_sequencer_unit regression: pass");
        end
        else
        begin
            $display("ultrasonic_bubble_detector_sequencer_unit regression: fail");
        end
        $finish;
    end

endmodule
